@@ design/dta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dta_pkg;

    localparam int FIELD_W    = 12;
    localparam int SLOT_W     = 4;
    localparam int USED_W     = 5;
    localparam int DIST_W     = 12;
    localparam int DIST_RESET = 50;

    localparam logic MODE_DETECT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] det_x;
        logic [FIELD_W-1:0] det_y;
        logic [FIELD_W-1:0] det_width;
        logic [FIELD_W-1:0] det_height;
        logic [SLOT_W-1:0]  read_slot;
    } t_det;

    typedef struct packed {
        logic               matched;
        logic               dropped;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] box_width;
        logic [FIELD_W-1:0] box_height;
        logic               slot_valid;
        logic [USED_W-1:0]  entries_used;
    } t_res;

endpackage

`default_nettype wire

@@ design/dta_det_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dta_det_if;
    import dta_pkg::*;

    logic valid;
    logic ready;
    t_det data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/dta_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dta_res_if;
    import dta_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/dta_sq_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Registered squared-difference unit: o_sq = (i_a - i_b)^2.
module dta_sq_unit #(
    parameter int OP_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic [OP_W-1:0]   i_a,
    input  wire logic [OP_W-1:0]   i_b,
    output logic      [2*OP_W-1:0] o_sq
);
    logic [OP_W-1:0]   w_diff;
    logic [2*OP_W-1:0] r_sq;

    always_comb begin
        w_diff = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
    end

    always_ff @(posedge i_clk) begin
        r_sq <= (2*OP_W)'(w_diff) * (2*OP_W)'(w_diff);
    end

    assign o_sq = r_sq;
endmodule

`default_nettype wire

@@ design/dta_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Track table: one write port, one registered read port.
module dta_table #(
    parameter int DEPTH  = 16,
    parameter int IDX_W  = 4,
    parameter int DATA_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [IDX_W-1:0]  i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

@@ design/detection_track_associator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Read item: the entry read in S_RDW goes to the result register, then to the output register.
// Detection: the squarer takes one radius pass, then x and y for each compared entry,
// until an entry matches or all used entries have been compared.
// One item in flight: ready returns as the result registers, so a new item is taken
// only once the last one is done; a result waits in S_DONE while the previous one waits for o_res.ready.
// Reset: sync, active low; clears entry count, output valid, radius to 50; table kept.
module detection_track_associator #(
    parameter int TABLE_DEPTH = 16,
    parameter int COORD_WIDTH = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dta_det_if.sink                   i_det,
    dta_res_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [dta_pkg::DIST_W-1:0] i_cfg_wdata
);
    import dta_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W  = (COORD_WIDTH > DIST_W) ? COORD_WIDTH : DIST_W;
    localparam int SQ_W  = 2 * OP_W;
    localparam int ENT_W = 4 * COORD_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LIM  = 3'd1;
    localparam logic [2:0] S_LIMW = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SQY  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_RDW  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] w;
        logic [COORD_WIDTH-1:0] h;
    } t_entry;

    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DIST_W-1:0]      r_near;
    logic                   r_out_valid, n_out_valid;
    t_res                   r_out, n_out;
    t_res                   r_res, n_res;
    logic [COORD_WIDTH-1:0] r_x, n_x, r_y, n_y, r_w, n_w, r_h, n_h;
    logic [SLOT_W-1:0]      r_rslot, n_rslot;
    logic                   r_hit, n_hit;
    logic [SQ_W-1:0]        r_lim, n_lim;
    logic [SQ_W-1:0]        r_acc, n_acc;

    logic                   w_accept;
    logic [31:0]            w_in_x, w_in_y, w_in_w, w_in_h, w_rs32;
    logic [OP_W-1:0]        w_ua, w_ub;
    logic [SQ_W-1:0]        w_sq;
    logic [SQ_W:0]          w_sum;
    logic [COORD_WIDTH:0]   w_sx, w_sy;
    logic [ENT_W-1:0]       w_rdata;
    t_entry                 w_rd;
    t_entry                 w_wentry;
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [31:0]            w_o_x, w_o_y, w_o_w, w_o_h, w_o_idx, w_o_cnt, w_o_cnt1;

    assign w_accept    = i_det.valid && i_det.ready;
    assign i_det.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Inputs masked or extended to the coordinate width.
    assign w_in_x = 32'(i_det.data.det_x);
    assign w_in_y = 32'(i_det.data.det_y);
    assign w_in_w = 32'(i_det.data.det_width);
    assign w_in_h = 32'(i_det.data.det_height);
    assign w_rs32 = 32'(i_det.data.read_slot);

    assign w_rd = t_entry'(w_rdata);
    assign w_sx = {1'b0, w_rd.x} + {1'b0, r_x};
    assign w_sy = {1'b0, w_rd.y} + {1'b0, r_y};
    assign w_sum = {1'b0, r_acc} + {1'b0, w_sq};

    dta_sq_unit #(
        .OP_W (OP_W)
    ) u_sq (
        .i_clk (i_clk),
        .i_a   (w_ua),
        .i_b   (w_ub),
        .o_sq  (w_sq)
    );

    dta_table #(
        .DEPTH  (TABLE_DEPTH),
        .IDX_W  (IDX_W),
        .DATA_W (ENT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_raddr (n_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        // Squarer operand select: radius, then x and y per entry.
        case (r_state)
            S_LIM: begin
                w_ua = OP_W'(r_near);
                w_ub = '0;
            end
            S_SQY: begin
                w_ua = OP_W'(w_rd.y);
                w_ub = OP_W'(r_y);
            end
            default: begin
                w_ua = OP_W'(w_rd.x);
                w_ub = OP_W'(r_x);
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        n_res       = r_res;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_rslot     = r_rslot;
        n_hit       = r_hit;
        n_lim       = r_lim;
        n_acc       = r_acc;
        w_we        = 1'b0;
        w_waddr     = r_idx[IDX_W-1:0];
        w_wentry    = '{x: r_x, y: r_y, w: r_w, h: r_h};

        w_o_x    = 32'(w_rd.x);
        w_o_y    = 32'(w_rd.y);
        w_o_w    = 32'(w_rd.w);
        w_o_h    = 32'(w_rd.h);
        w_o_idx  = 32'(r_idx);
        w_o_cnt  = 32'(r_cnt);
        w_o_cnt1 = 32'(r_cnt) + 32'd1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_x     = w_in_x[COORD_WIDTH-1:0];
                    n_y     = w_in_y[COORD_WIDTH-1:0];
                    n_w     = w_in_w[COORD_WIDTH-1:0];
                    n_h     = w_in_h[COORD_WIDTH-1:0];
                    n_rslot = i_det.data.read_slot;
                    n_hit   = (w_rs32 < 32'(r_cnt));
                    if (i_det.data.mode == MODE_READ) begin
                        n_idx   = w_rs32[CNT_W-1:0];
                        n_state = S_RDW;
                    end else begin
                        n_idx   = '0;
                        n_state = S_LIM;
                    end
                end
            end
            S_LIM: begin
                n_state = S_LIMW;
            end
            S_LIMW: begin
                n_lim   = w_sq;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_idx < r_cnt) begin
                    n_state = S_SQY;
                end else if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    // No match: append at the end of the table.
                    w_we     = 1'b1;
                    w_waddr  = r_cnt[IDX_W-1:0];
                    n_cnt    = r_cnt + 1'b1;
                    w_o_x    = 32'(r_x);
                    w_o_y    = 32'(r_y);
                    w_o_w    = 32'(r_w);
                    w_o_h    = 32'(r_h);
                    n_res    = '{matched: 1'b0, dropped: 1'b0,
                                 slot: w_o_cnt[SLOT_W-1:0],
                                 pos_x: w_o_x[FIELD_W-1:0], pos_y: w_o_y[FIELD_W-1:0],
                                 box_width: w_o_w[FIELD_W-1:0],
                                 box_height: w_o_h[FIELD_W-1:0],
                                 slot_valid: 1'b1, entries_used: w_o_cnt1[USED_W-1:0]};
                    n_state  = S_DONE;
                end else begin
                    n_res    = '{matched: 1'b0, dropped: 1'b1, slot: '0,
                                 pos_x: '0, pos_y: '0, box_width: '0, box_height: '0,
                                 slot_valid: 1'b0, entries_used: w_o_cnt[USED_W-1:0]};
                    n_state  = S_DONE;
                end
            end
            S_SQY: begin
                n_acc   = w_sq;
                n_state = S_SUM;
            end
            S_SUM: begin
                if (w_sum < {1'b0, r_lim}) begin
                    w_we     = 1'b1;
                    w_wentry = '{x: w_sx[COORD_WIDTH:1], y: w_sy[COORD_WIDTH:1],
                                 w: r_w, h: r_h};
                    w_o_x    = 32'(w_sx[COORD_WIDTH:1]);
                    w_o_y    = 32'(w_sy[COORD_WIDTH:1]);
                    w_o_w    = 32'(r_w);
                    w_o_h    = 32'(r_h);
                    n_res    = '{matched: 1'b1, dropped: 1'b0,
                                 slot: w_o_idx[SLOT_W-1:0],
                                 pos_x: w_o_x[FIELD_W-1:0], pos_y: w_o_y[FIELD_W-1:0],
                                 box_width: w_o_w[FIELD_W-1:0],
                                 box_height: w_o_h[FIELD_W-1:0],
                                 slot_valid: 1'b1, entries_used: w_o_cnt[USED_W-1:0]};
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CHK;
                end
            end
            S_RDW: begin
                if (r_hit) begin
                    n_res = '{matched: 1'b0, dropped: 1'b0, slot: r_rslot,
                              pos_x: w_o_x[FIELD_W-1:0], pos_y: w_o_y[FIELD_W-1:0],
                              box_width: w_o_w[FIELD_W-1:0],
                              box_height: w_o_h[FIELD_W-1:0],
                              slot_valid: 1'b1, entries_used: w_o_cnt[USED_W-1:0]};
                end else begin
                    n_res = '{matched: 1'b0, dropped: 1'b0, slot: r_rslot,
                              pos_x: '0, pos_y: '0, box_width: '0, box_height: '0,
                              slot_valid: 1'b0, entries_used: w_o_cnt[USED_W-1:0]};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_near      <= DIST_W'(DIST_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_near <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_res   <= n_res;
        r_x     <= n_x;
        r_y     <= n_y;
        r_w     <= n_w;
        r_h     <= n_h;
        r_rslot <= n_rslot;
        r_hit   <= n_hit;
        r_lim   <= n_lim;
        r_acc   <= n_acc;
    end
endmodule

`default_nettype wire

@@ design/dta_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dta_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          i_in_ready,
    input wire logic          i_out_valid,
    input wire logic          i_out_ready,
    input wire dta_pkg::t_res i_out_data
);
    import dta_pkg::*;

    // Stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // One item in flight: ready drops after an input transfer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.matched |-> i_out_data.slot_valid && !i_out_data.dropped)
        else $error("matched result without valid slot");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.dropped |->
            !i_out_data.slot_valid && (i_out_data.slot == '0) && (i_out_data.pos_x == '0))
        else $error("dropped result carries entry data");
endmodule

bind detection_track_associator dta_checker u_dta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_det.valid),
    .i_in_ready  (i_det.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire
